FILE: rtl/rce_pkg.sv
// ============================================================================
// Room clarity energy ratios: shared package
// Types, widths and constants used by the clarity front end, the snapshot
// queue, the log2 unit and the ratio back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rce_pkg;

    // Energy accumulators and configuration
    localparam int ENERGY_W    = 48;
    localparam int LEN_W       = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int IN_TDATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_EARLY50 = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EARLY80 = 8'd1;

    localparam logic [LEN_W-1:0] EARLY50_RESET = 16'd2400;
    localparam logic [LEN_W-1:0] EARLY80_RESET = 16'd3840;

    // Fixed-point log2: integer part is the top set bit, fraction in Q.20
    localparam int LOG_FRAC   = 20;
    localparam int LZ_W       = 6;
    localparam int LOG_W      = LZ_W + LOG_FRAC;
    localparam int MANT_W     = 31;
    localparam int ITER_W     = 5;
    localparam int COARSE_SHIFT = 8;

    // dB conversion: 10*log10(2) in Q.24, product rounded at bit 36
    localparam int SCALE_W    = 26;
    localparam int DB_PROD_W  = LOG_W + SCALE_W;
    localparam int DB_SHIFT   = 36;
    localparam int DB_W       = 16;
    localparam int DB_MAG_W   = DB_PROD_W + 1 - DB_SHIFT;
    localparam logic [SCALE_W-1:0]   DB_SCALE     = 26'd50504453;
    localparam logic [DB_PROD_W:0]   DB_HALF      = 53'h8_0000_0000;
    localparam logic [DB_W-1:0]      DB_LIMIT_POS = 16'h6300;
    localparam logic [DB_W-1:0]      DB_LIMIT_NEG = 16'h9D00;

    // D50 ratio in Q1.16 by restoring division
    localparam int RATIO_W    = 17;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = 4;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'd65536;

    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * DB_W - RATIO_W;

    // Snapshot queue between the front end and the back end
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_LEVEL_W = 2;

    // Operand order of the four logarithms
    localparam logic [1:0] OP_EARLY50 = 2'd0;
    localparam logic [1:0] OP_LATE50  = 2'd1;
    localparam logic [1:0] OP_EARLY80 = 2'd2;
    localparam logic [1:0] OP_LATE80  = 2'd3;

    typedef struct packed {
        logic [ENERGY_W-1:0] total;
        logic [ENERGY_W-1:0] early50;
        logic [ENERGY_W-1:0] early80;
    } energy_snap_t;

    typedef struct packed {
        logic                     not_empty;
        logic [QUEUE_LEVEL_W-1:0] level;
    } queue_status_t;

    typedef enum logic [1:0] {
        LOG_IDLE,
        LOG_COARSE,
        LOG_FINE,
        LOG_SQUARE
    } log_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOG_START,
        BK_LOG_WAIT,
        BK_DB_MUL,
        BK_DB_ROUND,
        BK_DIV_STEP,
        BK_DIV_ROUND,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/room_clarity_energy_ratios_core.sv
// ============================================================================
// Room clarity energy ratios core
// Measures C50, C80 and D50 of one band-limited impulse response streamed
// one Q1.15 sample per transfer, with tlast on the final sample. Samples are
// taken at one per clock while s_tready is high: each is squared and added
// to the total energy and, while its position is below early50_len or
// early80_len, to the early energies. On the last sample the three energies
// go into a two-entry queue and the accumulators clear, so the next response
// can stream in at once. A back end turns each queued snapshot into one
// result: C50 and C80 as 10*log10(early/late) in signed Q8.8 dB clamped to
// +-99 dB (+99 dB when the late energy is zero), and D50 as early/total in
// Q1.16 (0 for a silent response). Results come from the shared iterative
// log2 unit (per nonzero energy: up to 14 normalizing steps, 20 squaring
// steps and their handshakes), the two dB conversions and the 16-step D50
// division. When two results are waiting in the queue, s_tready drops
// until the back end takes one. The user must write window lengths through
// the cfg port only while the core is idle; the core leaves this unchecked.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module room_clarity_energy_ratios_core #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // Sample stream; tdata[15:0] = sample, tlast = last
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [rce_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  wire                                  s_tlast,
    // Result stream; tdata[15:0] = c50_db, [31:16] = c80_db, [48:32] = d50_ratio
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [rce_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // Register writes
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [rce_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire  [rce_pkg::LEN_W-1:0]            cfg_data
);

    logic [rce_pkg::LEN_W-1:0]       early50_len_reg;
    logic [rce_pkg::LEN_W-1:0]       early80_len_reg;
    logic                            q_push;
    rce_pkg::energy_snap_t           q_push_snap;
    logic                            q_pop;
    rce_pkg::energy_snap_t           q_head;
    rce_pkg::queue_status_t          q_status;
    logic                            log_start;
    logic [rce_pkg::ENERGY_W-1:0]    log_operand;
    logic                            log_done;
    logic [rce_pkg::LOG_W-1:0]       log_result;

    // Window length registers; writes to unused indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            early50_len_reg <= rce_pkg::EARLY50_RESET;
            early80_len_reg <= rce_pkg::EARLY80_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rce_pkg::CFG_EARLY50: early50_len_reg <= cfg_data;
                rce_pkg::CFG_EARLY80: early80_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sample accumulation.
    rce_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .early50_len (early50_len_reg),
        .early80_len (early80_len_reg),
        .queue_level (q_status.level),
        .push        (q_push),
        .push_snap   (q_push_snap)
    );

    // Snapshot queue.
    rce_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_snap (q_push_snap),
        .pop       (q_pop),
        .head_snap (q_head),
        .status    (q_status)
    );

    // Shared log2 unit.
    rce_log2 u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (log_start),
        .operand (log_operand),
        .done    (log_done),
        .result  (log_result)
    );

    // Ratio computation and output register.
    rce_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .log_start   (log_start),
        .log_operand (log_operand),
        .log_done    (log_done),
        .log_result  (log_result),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // A finished response never finds the queue full.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_status.level < rce_pkg::QUEUE_LEVEL_W'(rce_pkg::QUEUE_DEPTH)))
        else $error("snapshot pushed into a full queue");

    // Early energies never exceed the total, so the late energies never wrap.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> ((q_push_snap.early50 <= q_push_snap.total) &&
                    (q_push_snap.early80 <= q_push_snap.total)))
        else $error("early energy above total energy");

    // The log2 unit never signals done right after being started.
    assert property (@(posedge clk) disable iff (!rst_n)
        log_start |=> !log_done)
        else $error("log2 unit finished right after start");

    // Clarity values stay inside the clamp and D50 stays at or below one.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(m_tdata[15:0]) <= 16'sd25344) &&
                      ($signed(m_tdata[15:0]) >= -16'sd25344) &&
                      ($signed(m_tdata[31:16]) <= 16'sd25344) &&
                      ($signed(m_tdata[31:16]) >= -16'sd25344) &&
                      (m_tdata[48:32] <= rce_pkg::RATIO_ONE)))
        else $error("result outside its range");

endmodule

`default_nettype wire

FILE: rtl/rce_front.sv
// ============================================================================
// Room clarity energy ratios: front end
// Accepts samples, squares them, classifies them against the early windows
// and accumulates the three energies; on the last sample it pushes a
// snapshot of the energies into the queue and clears the accumulators.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rce_front #(
    parameter int MAX_SAMPLES = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    input  wire  [rce_pkg::IN_TDATA_W-1:0]         s_tdata,
    input  wire                                    s_tlast,
    input  wire  [rce_pkg::LEN_W-1:0]              early50_len,
    input  wire  [rce_pkg::LEN_W-1:0]              early80_len,
    input  wire  [rce_pkg::QUEUE_LEVEL_W-1:0]      queue_level,
    output logic                                   push,
    output rce_pkg::energy_snap_t                  push_snap
);

    localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = (IDX_W > rce_pkg::LEN_W) ? IDX_W : rce_pkg::LEN_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int CNT_W = rce_pkg::QUEUE_LEVEL_W + 1;
    localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_SAMPLES);

    function automatic logic [rce_pkg::ENERGY_W-1:0] sat_add(
        input logic [rce_pkg::ENERGY_W-1:0] a,
        input logic [rce_pkg::ENERGY_W-1:0] b
    );
        logic [rce_pkg::ENERGY_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[rce_pkg::ENERGY_W] ? {rce_pkg::ENERGY_W{1'b1}}
                                    : s[rce_pkg::ENERGY_W-1:0];
    endfunction

    logic                          accept;
    logic [SAMPLE_BITS-1:0]        raw;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [SQ_W-1:0]               sq;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic                          a_valid_reg;
    logic                          a_last_reg;
    logic                          a_in50_reg;
    logic                          a_in80_reg;
    logic [SQ_W-1:0]               a_sq_reg;
    logic [rce_pkg::ENERGY_W-1:0]  sq_ext;
    logic [rce_pkg::ENERGY_W-1:0]  tot_reg;
    logic [rce_pkg::ENERGY_W-1:0]  e50_reg;
    logic [rce_pkg::ENERGY_W-1:0]  e80_reg;
    logic [rce_pkg::ENERGY_W-1:0]  tot_sum;
    logic [rce_pkg::ENERGY_W-1:0]  e50_sum;
    logic [rce_pkg::ENERGY_W-1:0]  e80_sum;
    logic [CNT_W-1:0]              committed;

    // Hold off new samples while a finished response could find the queue full.
    assign committed = CNT_W'(queue_level) + CNT_W'(a_valid_reg & a_last_reg);
    assign s_tready  = committed < CNT_W'(rce_pkg::QUEUE_DEPTH);
    assign accept    = s_tvalid & s_tready;

    // Magnitude of the sample taken as a SAMPLE_BITS two's complement value.
    assign raw = SAMPLE_BITS'(s_tdata);
    assign mag = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
    assign sq  = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

    // Position of the next sample; it holds at the limit on long responses.
    always_comb
    begin
        idx_next = idx_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                idx_next = '0;
            end
            else if (idx_reg < IDX_LIMIT)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // Saturating sums with the squared sample of the accumulate stage.
    assign sq_ext = rce_pkg::ENERGY_W'(a_sq_reg);

    always_comb
    begin
        tot_sum = sat_add(tot_reg, sq_ext);
        e50_sum = a_in50_reg ? sat_add(e50_reg, sq_ext) : e50_reg;
        e80_sum = a_in80_reg ? sat_add(e80_reg, sq_ext) : e80_reg;
        push_snap.total   = tot_sum;
        push_snap.early50 = e50_sum;
        push_snap.early80 = e80_sum;
    end

    assign push = a_valid_reg & a_last_reg;

    // Control state of the square and accumulate stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_last_reg  <= 1'b0;
            a_in50_reg  <= 1'b0;
            a_in80_reg  <= 1'b0;
            tot_reg     <= '0;
            e50_reg     <= '0;
            e80_reg     <= '0;
        end
        else
        begin
            idx_reg     <= idx_next;
            a_valid_reg <= accept;
            if (accept)
            begin
                a_last_reg <= s_tlast;
                a_in50_reg <= CMP_W'(idx_reg) < CMP_W'(early50_len);
                a_in80_reg <= CMP_W'(idx_reg) < CMP_W'(early80_len);
            end
            if (a_valid_reg)
            begin
                if (a_last_reg)
                begin
                    tot_reg <= '0;
                    e50_reg <= '0;
                    e80_reg <= '0;
                end
                else
                begin
                    tot_reg <= tot_sum;
                    e50_reg <= e50_sum;
                    e80_reg <= e80_sum;
                end
            end
        end
    end

    // Squared sample register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_sq_reg <= sq;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rce_queue.sv
// ============================================================================
// Room clarity energy ratios: snapshot queue
// Short first-in first-out queue of energy snapshots that decouples the
// accumulating front end from the ratio back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rce_queue (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        push,
    input  rce_pkg::energy_snap_t      push_snap,
    input  wire                        pop,
    output rce_pkg::energy_snap_t      head_snap,
    output rce_pkg::queue_status_t     status
);

    rce_pkg::energy_snap_t                 entry_reg [rce_pkg::QUEUE_DEPTH];
    logic [rce_pkg::QUEUE_PTR_W-1:0]       wr_ptr_reg;
    logic [rce_pkg::QUEUE_PTR_W-1:0]       rd_ptr_reg;
    logic [rce_pkg::QUEUE_LEVEL_W-1:0]     level_reg;
    logic [rce_pkg::QUEUE_LEVEL_W-1:0]     level_next;

    assign head_snap        = entry_reg[rd_ptr_reg];
    assign status.level     = level_reg;
    assign status.not_empty = level_reg != '0;

    // Fill level follows the pushes and pops of each cycle.
    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Snapshot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_snap;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rce_log2.sv
// ============================================================================
// Room clarity energy ratios: iterative log2 unit
// Normalizes a nonzero 48-bit energy by coarse and fine shifts, then builds
// a 20-bit fraction by repeated squaring of the Q1.30 mantissa, one bit per
// cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rce_log2 (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    input  wire  [rce_pkg::ENERGY_W-1:0]     operand,
    output logic                             done,
    output logic [rce_pkg::LOG_W-1:0]        result
);

    localparam int EW = rce_pkg::ENERGY_W;
    localparam int MW = rce_pkg::MANT_W;
    localparam logic [rce_pkg::LZ_W-1:0]   TOP_BIT   = rce_pkg::LZ_W'(EW - 1);
    localparam logic [rce_pkg::ITER_W-1:0] LAST_ITER = rce_pkg::ITER_W'(rce_pkg::LOG_FRAC - 1);

    rce_pkg::log_state_t                state_reg;
    rce_pkg::log_state_t                state_next;
    logic [EW-1:0]                      norm_reg;
    logic [EW-1:0]                      norm_next;
    logic [rce_pkg::LZ_W-1:0]           lz_reg;
    logic [rce_pkg::LZ_W-1:0]           lz_next;
    logic [MW-1:0]                      mant_reg;
    logic [MW-1:0]                      mant_next;
    logic [rce_pkg::LOG_FRAC-1:0]       frac_reg;
    logic [rce_pkg::LOG_FRAC-1:0]       frac_next;
    logic [rce_pkg::ITER_W-1:0]         iter_reg;
    logic [rce_pkg::ITER_W-1:0]         iter_next;
    logic                               done_reg;
    logic                               done_next;
    logic [2*MW-1:0]                    square;
    logic [MW:0]                        scaled;

    // Mantissa squared and brought back to Q1.30 (may reach 2.0 and above).
    assign square = {{MW{1'b0}}, mant_reg} * {{MW{1'b0}}, mant_reg};
    assign scaled = square[2*MW-1:MW-1];

    assign done   = done_reg;
    assign result = {TOP_BIT - lz_reg, frac_reg};

    // Sequencer: coarse shift by bytes, fine shift by bits, then squaring.
    always_comb
    begin
        state_next = state_reg;
        norm_next  = norm_reg;
        lz_next    = lz_reg;
        mant_next  = mant_reg;
        frac_next  = frac_reg;
        iter_next  = iter_reg;
        done_next  = 1'b0;
        case (state_reg)
            rce_pkg::LOG_IDLE:
            begin
                if (start)
                begin
                    norm_next  = operand;
                    lz_next    = '0;
                    state_next = rce_pkg::LOG_COARSE;
                end
            end
            rce_pkg::LOG_COARSE:
            begin
                if (norm_reg[EW-1:EW-rce_pkg::COARSE_SHIFT] == '0)
                begin
                    norm_next = norm_reg << rce_pkg::COARSE_SHIFT;
                    lz_next   = lz_reg + rce_pkg::LZ_W'(rce_pkg::COARSE_SHIFT);
                end
                else
                begin
                    state_next = rce_pkg::LOG_FINE;
                end
            end
            rce_pkg::LOG_FINE:
            begin
                if (!norm_reg[EW-1])
                begin
                    norm_next = norm_reg << 1;
                    lz_next   = lz_reg + 1'b1;
                end
                else
                begin
                    mant_next  = norm_reg[EW-1:EW-MW];
                    frac_next  = '0;
                    iter_next  = '0;
                    state_next = rce_pkg::LOG_SQUARE;
                end
            end
            rce_pkg::LOG_SQUARE:
            begin
                mant_next = scaled[MW] ? scaled[MW:1] : scaled[MW-1:0];
                frac_next = {frac_reg[rce_pkg::LOG_FRAC-2:0], scaled[MW]};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                begin
                    done_next  = 1'b1;
                    state_next = rce_pkg::LOG_IDLE;
                end
            end
            default:
            begin
                state_next = rce_pkg::LOG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rce_pkg::LOG_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
        lz_reg   <= lz_next;
        mant_reg <= mant_next;
        frac_reg <= frac_next;
        iter_reg <= iter_next;
    end

endmodule

`default_nettype wire

FILE: rtl/rce_back.sv
// ============================================================================
// Room clarity energy ratios: back end
// Takes one energy snapshot at a time, forms the four log2 values through
// the shared log2 unit, converts the differences to dB, divides the early
// 50 ms energy by the total and holds the result in the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rce_back (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  rce_pkg::queue_status_t               q_status,
    input  rce_pkg::energy_snap_t                q_head,
    output logic                                 q_pop,
    output logic                                 log_start,
    output logic [rce_pkg::ENERGY_W-1:0]         log_operand,
    input  wire                                  log_done,
    input  wire  [rce_pkg::LOG_W-1:0]            log_result,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [rce_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    localparam int EW = rce_pkg::ENERGY_W;
    localparam int LW = rce_pkg::LOG_W;
    localparam int PW = rce_pkg::DB_PROD_W;
    localparam int RW = rce_pkg::RATIO_W;
    localparam logic [rce_pkg::STEP_W-1:0] LAST_STEP = rce_pkg::STEP_W'(rce_pkg::DIV_STEPS - 1);

    rce_pkg::back_state_t        state_reg;
    rce_pkg::back_state_t        state_next;
    logic [EW-1:0]               tot_reg;
    logic [EW-1:0]               tot_next;
    logic [EW-1:0]               e50_reg;
    logic [EW-1:0]               e50_next;
    logic [EW-1:0]               late50_reg;
    logic [EW-1:0]               late50_next;
    logic [EW-1:0]               e80_reg;
    logic [EW-1:0]               e80_next;
    logic [EW-1:0]               late80_reg;
    logic [EW-1:0]               late80_next;
    logic [1:0]                  op_reg;
    logic [1:0]                  op_next;
    logic [3:0]                  zero_reg;
    logic [3:0]                  zero_next;
    logic [LW-1:0]               log_e50_reg;
    logic [LW-1:0]               log_e50_next;
    logic [LW-1:0]               log_l50_reg;
    logic [LW-1:0]               log_l50_next;
    logic [LW-1:0]               log_e80_reg;
    logic [LW-1:0]               log_e80_next;
    logic [LW-1:0]               log_l80_reg;
    logic [LW-1:0]               log_l80_next;
    logic                        pair_reg;
    logic                        pair_next;
    logic [PW-1:0]               prod_reg;
    logic [PW-1:0]               prod_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic [rce_pkg::DB_W-1:0]    c50_reg;
    logic [rce_pkg::DB_W-1:0]    c50_next;
    logic [rce_pkg::DB_W-1:0]    c80_reg;
    logic [rce_pkg::DB_W-1:0]    c80_next;
    logic [RW-1:0]               quo_reg;
    logic [RW-1:0]               quo_next;
    logic [EW-1:0]               rem_reg;
    logic [EW-1:0]               rem_next;
    logic [rce_pkg::STEP_W-1:0]  step_reg;
    logic [rce_pkg::STEP_W-1:0]  step_next;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [rce_pkg::DB_W-1:0]    out_c50_reg;
    logic [rce_pkg::DB_W-1:0]    out_c80_reg;
    logic [RW-1:0]               out_d50_reg;
    logic                        out_load;

    logic [LW-1:0]               sel_early;
    logic [LW-1:0]               sel_late;
    logic                        early_zero;
    logic                        late_zero;
    logic [LW:0]                 diff;
    logic [LW:0]                 diff_abs;
    logic [PW:0]                 rounded;
    logic [rce_pkg::DB_MAG_W-1:0] db_mag;
    logic [rce_pkg::DB_W-1:0]    db_clamped;
    logic [rce_pkg::DB_W-1:0]    db_value;
    logic [EW:0]                 rem_shift;
    logic [EW-1:0]               rem_half;

    // Operand of the log2 unit for the current step.
    always_comb
    begin
        case (op_reg)
            rce_pkg::OP_EARLY50: log_operand = e50_reg;
            rce_pkg::OP_LATE50:  log_operand = late50_reg;
            rce_pkg::OP_EARLY80: log_operand = e80_reg;
            default:             log_operand = late80_reg;
        endcase
    end

    // Early and late logs of the ratio in work (C50 first, then C80).
    always_comb
    begin
        sel_early  = pair_reg ? log_e80_reg : log_e50_reg;
        sel_late   = pair_reg ? log_l80_reg : log_l50_reg;
        early_zero = pair_reg ? zero_reg[rce_pkg::OP_EARLY80] : zero_reg[rce_pkg::OP_EARLY50];
        late_zero  = pair_reg ? zero_reg[rce_pkg::OP_LATE80] : zero_reg[rce_pkg::OP_LATE50];
        diff       = {1'b0, sel_early} - {1'b0, sel_late};
        diff_abs   = diff[LW] ? (~diff + 1'b1) : diff;
    end

    // Rounding to nearest with ties away from zero, clamp and sign.
    always_comb
    begin
        rounded    = {1'b0, prod_reg} + rce_pkg::DB_HALF;
        db_mag     = rounded[PW:rce_pkg::DB_SHIFT];
        db_clamped = (db_mag > rce_pkg::DB_MAG_W'(rce_pkg::DB_LIMIT_POS))
                     ? rce_pkg::DB_LIMIT_POS : db_mag[rce_pkg::DB_W-1:0];
        if (late_zero)
        begin
            db_value = rce_pkg::DB_LIMIT_POS;
        end
        else if (early_zero)
        begin
            db_value = rce_pkg::DB_LIMIT_NEG;
        end
        else if (neg_reg)
        begin
            db_value = ~db_clamped + 1'b1;
        end
        else
        begin
            db_value = db_clamped;
        end
    end

    // One restoring division step and the final rounding half.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_half  = tot_reg - rem_reg;

    assign out_load = (state_reg == rce_pkg::BK_OUT) && (!m_valid_reg || m_tready);

    // Sequencer over logs, dB conversions and the D50 division.
    always_comb
    begin
        state_next   = state_reg;
        tot_next     = tot_reg;
        e50_next     = e50_reg;
        late50_next  = late50_reg;
        e80_next     = e80_reg;
        late80_next  = late80_reg;
        op_next      = op_reg;
        zero_next    = zero_reg;
        log_e50_next = log_e50_reg;
        log_l50_next = log_l50_reg;
        log_e80_next = log_e80_reg;
        log_l80_next = log_l80_reg;
        pair_next    = pair_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        c50_next     = c50_reg;
        c80_next     = c80_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        q_pop        = 1'b0;
        log_start    = 1'b0;
        case (state_reg)
            rce_pkg::BK_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    q_pop       = 1'b1;
                    tot_next    = q_head.total;
                    e50_next    = q_head.early50;
                    late50_next = q_head.total - q_head.early50;
                    e80_next    = q_head.early80;
                    late80_next = q_head.total - q_head.early80;
                    op_next     = rce_pkg::OP_EARLY50;
                    state_next  = rce_pkg::BK_LOG_START;
                end
            end
            rce_pkg::BK_LOG_START:
            begin
                zero_next[op_reg] = log_operand == '0;
                if (log_operand == '0)
                begin
                    if (op_reg == rce_pkg::OP_LATE80)
                    begin
                        pair_next  = 1'b0;
                        state_next = rce_pkg::BK_DB_MUL;
                    end
                    else
                    begin
                        op_next = op_reg + 2'd1;
                    end
                end
                else
                begin
                    log_start  = 1'b1;
                    state_next = rce_pkg::BK_LOG_WAIT;
                end
            end
            rce_pkg::BK_LOG_WAIT:
            begin
                if (log_done)
                begin
                    case (op_reg)
                        rce_pkg::OP_EARLY50: log_e50_next = log_result;
                        rce_pkg::OP_LATE50:  log_l50_next = log_result;
                        rce_pkg::OP_EARLY80: log_e80_next = log_result;
                        default:             log_l80_next = log_result;
                    endcase
                    if (op_reg == rce_pkg::OP_LATE80)
                    begin
                        pair_next  = 1'b0;
                        state_next = rce_pkg::BK_DB_MUL;
                    end
                    else
                    begin
                        op_next    = op_reg + 2'd1;
                        state_next = rce_pkg::BK_LOG_START;
                    end
                end
            end
            rce_pkg::BK_DB_MUL:
            begin
                prod_next  = {{rce_pkg::SCALE_W{1'b0}}, diff_abs[LW-1:0]}
                           * {{LW{1'b0}}, rce_pkg::DB_SCALE};
                neg_next   = diff[LW];
                state_next = rce_pkg::BK_DB_ROUND;
            end
            rce_pkg::BK_DB_ROUND:
            begin
                if (!pair_reg)
                begin
                    c50_next   = db_value;
                    pair_next  = 1'b1;
                    state_next = rce_pkg::BK_DB_MUL;
                end
                else
                begin
                    c80_next = db_value;
                    if (tot_reg == '0)
                    begin
                        quo_next   = '0;
                        state_next = rce_pkg::BK_OUT;
                    end
                    else if (e50_reg == tot_reg)
                    begin
                        quo_next   = RW'(1);
                        rem_next   = '0;
                        step_next  = '0;
                        state_next = rce_pkg::BK_DIV_STEP;
                    end
                    else
                    begin
                        quo_next   = '0;
                        rem_next   = e50_reg;
                        step_next  = '0;
                        state_next = rce_pkg::BK_DIV_STEP;
                    end
                end
            end
            rce_pkg::BK_DIV_STEP:
            begin
                if (rem_shift >= {1'b0, tot_reg})
                begin
                    rem_next = EW'(rem_shift - {1'b0, tot_reg});
                    quo_next = {quo_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[EW-1:0];
                    quo_next = {quo_reg[RW-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = rce_pkg::BK_DIV_ROUND;
                end
            end
            rce_pkg::BK_DIV_ROUND:
            begin
                if (rem_reg >= rem_half)
                begin
                    quo_next = quo_reg + 1'b1;
                end
                state_next = rce_pkg::BK_OUT;
            end
            rce_pkg::BK_OUT:
            begin
                if (quo_reg > rce_pkg::RATIO_ONE)
                begin
                    quo_next = rce_pkg::RATIO_ONE;
                end
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    state_next   = rce_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rce_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rce_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        tot_reg     <= tot_next;
        e50_reg     <= e50_next;
        late50_reg  <= late50_next;
        e80_reg     <= e80_next;
        late80_reg  <= late80_next;
        op_reg      <= op_next;
        zero_reg    <= zero_next;
        log_e50_reg <= log_e50_next;
        log_l50_reg <= log_l50_next;
        log_e80_reg <= log_e80_next;
        log_l80_reg <= log_l80_next;
        pair_reg    <= pair_next;
        prod_reg    <= prod_next;
        neg_reg     <= neg_next;
        c50_reg     <= c50_next;
        c80_reg     <= c80_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
    end

    // Output register; the clamp on the ratio is applied as it loads.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_c50_reg <= c50_reg;
            out_c80_reg <= c80_reg;
            out_d50_reg <= (quo_reg > rce_pkg::RATIO_ONE) ? rce_pkg::RATIO_ONE : quo_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{rce_pkg::OUT_PAD_W{1'b0}}, out_d50_reg, out_c80_reg, out_c50_reg};

endmodule

`default_nettype wire
